// ===== hdl/ps2sc_pkg.sv =====
// Shared types, constants and the keymap table of the scancode translator.
package ps2sc_pkg;

    localparam logic [7:0] KEY_PREFIX = 8'hE0;
    localparam logic [6:0] K_LCTRL    = 7'h1D;
    localparam logic [6:0] K_LSHIFT   = 7'h2A;
    localparam logic [6:0] K_RSHIFT   = 7'h36;
    localparam logic [6:0] K_LALT     = 7'h38;
    localparam logic [6:0] K_CAPS     = 7'h3A;
    localparam logic [7:0] KEY_LIMIT  = 8'h3B;
    localparam logic [6:0] CH_LOWER_L = 7'h6C;
    localparam logic [6:0] CH_LOWER_U = 7'h75;
    localparam logic [6:0] CTRL_DELTA = 7'h60;

    typedef struct packed {
        logic ctrl;
        logic shift;
        logic alt;
        logic caps;
        logic prefix;
    } flags_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       unknown_key;
        logic       ctrl_down;
        logic       shift_down;
        logic       alt_down;
        logic       caps_on;
    } result_t;

    // Two-column keymap: returns the shifted column when upper is set.
    function automatic logic [6:0] keymap(input logic [5:0] idx, input logic upper);
        logic [13:0] pair;
        begin
            case (idx)
                6'h01: pair = {7'h1B, 7'h1B};
                6'h02: pair = {7'h21, 7'h31};
                6'h03: pair = {7'h40, 7'h32};
                6'h04: pair = {7'h23, 7'h33};
                6'h05: pair = {7'h24, 7'h34};
                6'h06: pair = {7'h25, 7'h35};
                6'h07: pair = {7'h5E, 7'h36};
                6'h08: pair = {7'h26, 7'h37};
                6'h09: pair = {7'h2A, 7'h38};
                6'h0A: pair = {7'h28, 7'h39};
                6'h0B: pair = {7'h29, 7'h30};
                6'h0C: pair = {7'h5F, 7'h2D};
                6'h0D: pair = {7'h2B, 7'h3D};
                6'h0E: pair = {7'h08, 7'h08};
                6'h0F: pair = {7'h09, 7'h09};
                6'h10: pair = {7'h51, 7'h71};
                6'h11: pair = {7'h57, 7'h77};
                6'h12: pair = {7'h45, 7'h65};
                6'h13: pair = {7'h52, 7'h72};
                6'h14: pair = {7'h54, 7'h74};
                6'h15: pair = {7'h59, 7'h79};
                6'h16: pair = {7'h55, 7'h75};
                6'h17: pair = {7'h49, 7'h69};
                6'h18: pair = {7'h4F, 7'h6F};
                6'h19: pair = {7'h50, 7'h70};
                6'h1A: pair = {7'h7B, 7'h5B};
                6'h1B: pair = {7'h7D, 7'h5D};
                6'h1C: pair = {7'h0D, 7'h0D};
                6'h1E: pair = {7'h41, 7'h61};
                6'h1F: pair = {7'h53, 7'h73};
                6'h20: pair = {7'h44, 7'h64};
                6'h21: pair = {7'h46, 7'h66};
                6'h22: pair = {7'h47, 7'h67};
                6'h23: pair = {7'h48, 7'h68};
                6'h24: pair = {7'h4A, 7'h6A};
                6'h25: pair = {7'h4B, 7'h6B};
                6'h26: pair = {7'h4C, 7'h6C};
                6'h27: pair = {7'h3A, 7'h3B};
                6'h28: pair = {7'h22, 7'h27};
                6'h29: pair = {7'h7E, 7'h60};
                6'h2B: pair = {7'h7C, 7'h5C};
                6'h2C: pair = {7'h5A, 7'h7A};
                6'h2D: pair = {7'h58, 7'h78};
                6'h2E: pair = {7'h43, 7'h63};
                6'h2F: pair = {7'h56, 7'h76};
                6'h30: pair = {7'h42, 7'h62};
                6'h31: pair = {7'h4E, 7'h6E};
                6'h32: pair = {7'h4D, 7'h6D};
                6'h33: pair = {7'h3C, 7'h2C};
                6'h34: pair = {7'h3E, 7'h2E};
                6'h35: pair = {7'h3F, 7'h2F};
                6'h37: pair = {7'h2A, 7'h2A};
                6'h39: pair = {7'h20, 7'h20};
                default: pair = 14'h0000;
            endcase
            keymap = upper ? pair[13:7] : pair[6:0];
        end
    endfunction

    // Digit and punctuation keys, whose case follows shift alone.
    function automatic logic shift_only_key(input logic [5:0] idx);
        begin
            shift_only_key = (idx < 6'h0E) || (idx == 6'h29) || (idx == 6'h1A) ||
                             (idx == 6'h1B) || (idx == 6'h2B) || (idx == 6'h27) ||
                             (idx == 6'h28) || (idx == 6'h33) || (idx == 6'h34) ||
                             (idx == 6'h35);
        end
    endfunction

endpackage

// ===== hdl/ps2sc_decode.sv =====
// Combinational decode of one scancode byte against the current modifier flags.
module ps2sc_decode (
    input  logic [7:0]        scan_byte,
    input  ps2sc_pkg::flags_t flags_cur,
    output ps2sc_pkg::flags_t flags_next,
    output ps2sc_pkg::result_t result
);
    import ps2sc_pkg::*;

    logic       is_prefix;
    logic       ext;
    logic       is_break;
    logic [6:0] low7;
    logic       handled;
    logic       upper;
    logic [6:0] ch_raw;
    logic [6:0] ch;

    always_comb begin
        is_prefix = (scan_byte == KEY_PREFIX);
        ext       = flags_cur.prefix;
        is_break  = scan_byte[7];
        low7      = scan_byte[6:0];
        // Extended makes only cover right ctrl and right alt.
        handled   = ext ? ((low7 == K_LCTRL) || (low7 == K_LALT)) && !is_break
                        : (scan_byte != 8'h00) && (scan_byte < KEY_LIMIT);
        upper     = (!ext && shift_only_key(low7[5:0])) ? flags_cur.shift
                                                        : (flags_cur.shift ^ flags_cur.caps);
        ch_raw    = keymap(low7[5:0], upper);
        ch        = ch_raw;
        if (flags_cur.ctrl && ((ch_raw == CH_LOWER_L) || (ch_raw == CH_LOWER_U))) begin
            ch = ch_raw - CTRL_DELTA;
        end

        flags_next         = flags_cur;
        result.char_valid  = 1'b0;
        result.char_code   = '0;
        result.unknown_key = 1'b0;

        if (is_prefix) begin
            flags_next.prefix = 1'b1;
        end else begin
            flags_next.prefix = 1'b0;
            if (is_break) begin
                if (low7 == K_LCTRL) begin
                    flags_next.ctrl = 1'b0;
                end else if (!ext && ((low7 == K_LSHIFT) || (low7 == K_RSHIFT))) begin
                    flags_next.shift = 1'b0;
                end else if (low7 == K_LALT) begin
                    flags_next.alt = 1'b0;
                end
            end else if (handled) begin
                if (ch != 7'h00) begin
                    result.char_valid = 1'b1;
                    result.char_code  = ch;
                end else if (low7 == K_LCTRL) begin
                    flags_next.ctrl = 1'b1;
                end else if ((low7 == K_LSHIFT) || (low7 == K_RSHIFT)) begin
                    flags_next.shift = 1'b1;
                end else if (low7 == K_LALT) begin
                    flags_next.alt = 1'b1;
                end else if (low7 == K_CAPS) begin
                    flags_next.caps = !flags_cur.caps;
                end
            end else begin
                result.unknown_key = 1'b1;
            end
        end

        result.ctrl_down  = flags_next.ctrl;
        result.shift_down = flags_next.shift;
        result.alt_down   = flags_next.alt;
        result.caps_on    = flags_next.caps;
    end

endmodule

// ===== hdl/ps2_scancode_to_ascii.sv =====
// Throughput: one item per cycle while m_ready is held high; the input register and the result register
// form a two-stage pipeline and the decode between them is a single table lookup.
// Reset (aresetn low, synchronous) empties both stages and clears all modifier
// flags and the extended prefix.
module ps2_scancode_to_ascii (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [6:0] m_char_code,
    output logic       m_unknown_key,
    output logic       m_ctrl_down,
    output logic       m_shift_down,
    output logic       m_alt_down,
    output logic       m_caps_on
);
    import ps2sc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result_next;
    logic       advance;

    // The item in the input register moves on when the result register is empty or its item is taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ps2sc_decode u_decode (
        .scan_byte (in_byte_reg),
        .flags_cur (flags_reg),
        .flags_next(flags_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_scan_byte;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_char_valid  = out_reg.char_valid;
    assign m_char_code   = out_reg.char_code;
    assign m_unknown_key = out_reg.unknown_key;
    assign m_ctrl_down   = out_reg.ctrl_down;
    assign m_shift_down  = out_reg.shift_down;
    assign m_alt_down    = out_reg.alt_down;
    assign m_caps_on     = out_reg.caps_on;

endmodule

// ===== hdl/ps2sc_checker.sv =====
// Port-level checks of the scancode translator, bound to the top level.
module ps2sc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_scan_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_char_valid,
    input logic [6:0] m_char_code,
    input logic       m_unknown_key,
    input logic       m_ctrl_down,
    input logic       m_shift_down,
    input logic       m_alt_down,
    input logic       m_caps_on
);

    // A stalled result item keeps its character.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_char_valid))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item shown right after reset");

    // The character flag and the code must agree.
    a_char_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_valid == (m_char_code != 7'h00)))
        else $error("char_valid disagrees with char_code");

    a_unknown_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unknown_key |-> !m_char_valid && (m_char_code == 7'h00))
        else $error("unknown key item carries a character");

endmodule

bind ps2_scancode_to_ascii ps2sc_checker u_ps2sc_checker (.*);

// ===== dv/tb.sv =====
// Testbench for ps2_scancode_to_ascii: random and directed scancodes checked against a key decoder.
`timescale 1ns / 100ps

module tb;
    import ps2sc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_ITEMS   = 1050;
    localparam int          LONG_STALL     = 60;
    localparam logic [7:0]  SC_NULL        = 8'h00;
    localparam logic [7:0]  SC_1           = 8'h02;
    localparam logic [7:0]  SC_Q           = 8'h10;
    localparam logic [7:0]  SC_U           = 8'h16;
    localparam logic [7:0]  SC_L           = 8'h26;
    localparam logic [7:0]  SC_HOME        = 8'h47;
    localparam logic [7:0]  SC_LAST_MAKE   = 8'h3A;
    localparam logic [7:0]  SC_BREAK       = 8'h80;
    localparam logic [7:0]  SC_ALL_ONES    = 8'hFF;

    typedef struct packed {
        logic       hold;
        logic [7:0] code;
    } scan_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_char_valid;
    logic [6:0] m_char_code;
    logic       m_unknown_key;
    logic       m_ctrl_down;
    logic       m_shift_down;
    logic       m_alt_down;
    logic       m_caps_on;

    scan_item_t  pending[$];
    result_t     exp_keys[$];
    flags_t      kbd = '0;
    logic        s_fire = 1'b0;
    int          errors = 0;
    int          out_count = 0;
    int          quiet_cycles = 0;
    int          in_gap = 0;
    int          stall_left = 0;
    bit          long_done = 1'b0;
    logic        next_valid;
    logic [7:0]  next_byte;
    logic        next_ready;
    scan_item_t  item;
    result_t     want;
    result_t     got;
    result_t     decoded;

    ps2_scancode_to_ascii u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_scan_byte   (s_scan_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_valid  (m_char_valid),
        .m_char_code   (m_char_code),
        .m_unknown_key (m_unknown_key),
        .m_ctrl_down   (m_ctrl_down),
        .m_shift_down  (m_shift_down),
        .m_alt_down    (m_alt_down),
        .m_caps_on     (m_caps_on)
    );

    always #6 aclk = ~aclk;

    // Key characters as {unshifted, shifted}; zero marks a modifier or an unused slot.
    function automatic logic [15:0] key_chars(input logic [7:0] k);
        begin
            case (k)
                8'h01: key_chars = {8'h1B, 8'h1B};
                8'h02: key_chars = "1!";  8'h03: key_chars = "2@";  8'h04: key_chars = "3#";
                8'h05: key_chars = "4$";  8'h06: key_chars = "5%";  8'h07: key_chars = "6^";
                8'h08: key_chars = "7&";  8'h09: key_chars = "8*";  8'h0A: key_chars = "9(";
                8'h0B: key_chars = "0)";  8'h0C: key_chars = "-_";  8'h0D: key_chars = "=+";
                8'h0E: key_chars = {8'h08, 8'h08};
                8'h0F: key_chars = {8'h09, 8'h09};
                8'h10: key_chars = "qQ";  8'h11: key_chars = "wW";  8'h12: key_chars = "eE";
                8'h13: key_chars = "rR";  8'h14: key_chars = "tT";  8'h15: key_chars = "yY";
                8'h16: key_chars = "uU";  8'h17: key_chars = "iI";  8'h18: key_chars = "oO";
                8'h19: key_chars = "pP";  8'h1A: key_chars = "[{";  8'h1B: key_chars = "]}";
                8'h1C: key_chars = {8'h0D, 8'h0D};
                8'h1E: key_chars = "aA";  8'h1F: key_chars = "sS";  8'h20: key_chars = "dD";
                8'h21: key_chars = "fF";  8'h22: key_chars = "gG";  8'h23: key_chars = "hH";
                8'h24: key_chars = "jJ";  8'h25: key_chars = "kK";  8'h26: key_chars = "lL";
                8'h27: key_chars = ";:";  8'h28: key_chars = "'\"";  8'h29: key_chars = "`~";
                8'h2B: key_chars = "\\|";
                8'h2C: key_chars = "zZ";  8'h2D: key_chars = "xX";  8'h2E: key_chars = "cC";
                8'h2F: key_chars = "vV";  8'h30: key_chars = "bB";  8'h31: key_chars = "nN";
                8'h32: key_chars = "mM";  8'h33: key_chars = ",<";  8'h34: key_chars = ".>";
                8'h35: key_chars = "/?";  8'h37: key_chars = "**";  8'h39: key_chars = "  ";
                default: key_chars = 16'h0000;
            endcase
        end
    endfunction

    // Digits and punctuation ignore caps lock.
    function automatic logic caps_immune(input logic [7:0] k);
        begin
            case (k)
                8'h1A, 8'h1B, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h33, 8'h34, 8'h35: caps_immune = 1'b1;
                default: caps_immune = (k < 8'h0E);
            endcase
        end
    endfunction

    task automatic decode_scan(input logic [7:0] b, output result_t r);
        logic        ext;
        logic        upper;
        logic [15:0] chars;
        logic [6:0]  ch;
        logic        unk;
        begin
            ext = 1'b0;
            ch  = '0;
            unk = 1'b0;
            if (b == KEY_PREFIX) begin
                kbd.prefix = 1'b1;
            end else begin
                ext = kbd.prefix;
                kbd.prefix = 1'b0;
                if (b[7]) begin
                    // Ctrl and alt have extended right-hand twins; shift does not.
                    if (b[6:0] == K_LCTRL)
                        kbd.ctrl = 1'b0;
                    else if (!ext && (b[6:0] == K_LSHIFT || b[6:0] == K_RSHIFT))
                        kbd.shift = 1'b0;
                    else if (b[6:0] == K_LALT)
                        kbd.alt = 1'b0;
                end else if ((!ext && b != SC_NULL && b < KEY_LIMIT) ||
                             (ext && (b[6:0] == K_LCTRL || b[6:0] == K_LALT))) begin
                    upper = (!ext && caps_immune(b)) ? kbd.shift : (kbd.shift ^ kbd.caps);
                    chars = key_chars(b);
                    ch = upper ? chars[6:0] : chars[14:8];
                    // Ctrl folds lowercase l and u onto their control codes.
                    if (kbd.ctrl && (ch == CH_LOWER_L || ch == CH_LOWER_U))
                        ch = ch & 7'h1F;
                    if (ch == '0) begin
                        if (b[6:0] == K_LCTRL)
                            kbd.ctrl = 1'b1;
                        else if (b[6:0] == K_LSHIFT || b[6:0] == K_RSHIFT)
                            kbd.shift = 1'b1;
                        else if (b[6:0] == K_LALT)
                            kbd.alt = 1'b1;
                        else if (b[6:0] == K_CAPS)
                            kbd.caps = ~kbd.caps;
                    end
                end else begin
                    unk = 1'b1;
                end
            end
            r.char_valid  = (ch != '0);
            r.char_code   = ch;
            r.unknown_key = unk;
            r.ctrl_down   = kbd.ctrl;
            r.shift_down  = kbd.shift;
            r.alt_down    = kbd.alt;
            r.caps_on     = kbd.caps;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        begin
            if (exp_v != act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] c);
        scan_item_t it;
        begin
            it.code = c;
            // One item midway makes the sender wait for every result to come back.
            it.hold = (pending.size() == 600);
            pending.push_back(it);
        end
    endtask

    // Result side: check, then predict what was just accepted, then watch for a hang.
    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_count++;
                if (exp_keys.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = exp_keys.pop_front();
                    got  = {m_char_valid, m_char_code, m_unknown_key, m_ctrl_down,
                            m_shift_down, m_alt_down, m_caps_on};
                    check_field("char_valid",  want.char_valid,  got.char_valid);
                    check_field("char_code",   want.char_code,   got.char_code);
                    check_field("unknown_key", want.unknown_key, got.unknown_key);
                    check_field("ctrl_down",   want.ctrl_down,   got.ctrl_down);
                    check_field("shift_down",  want.shift_down,  got.shift_down);
                    check_field("alt_down",    want.alt_down,    got.alt_down);
                    check_field("caps_on",     want.caps_on,     got.caps_on);
                end
            end
            if (s_valid && s_ready) begin
                decode_scan(s_scan_byte, decoded);
                exp_keys.push_back(decoded);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("[ps2_scancode_to_ascii] ERROR");
                    $finish;
                end
            end
        end
    end

    // Sender.
    always @(negedge aclk) begin
        if (aresetn) begin
            next_valid = s_valid;
            next_byte  = s_scan_byte;
            if (!s_valid || s_fire) begin
                next_valid = 1'b0;
                if (pending.size() != 0) begin
                    if (pending[0].hold && exp_keys.size() != 0) begin
                        next_valid = 1'b0;
                    end else if (in_gap != 0) begin
                        in_gap--;
                    end else if (pending.size() >= 100 && ((pending.size() / 80) % 3) != 0 &&
                                 $urandom_range(0, 4) == 0) begin
                        in_gap = $urandom_range(1, 5) - 1;
                    end else begin
                        item = pending.pop_front();
                        next_valid = 1'b1;
                        next_byte  = item.code;
                    end
                end
            end
            s_valid     <= next_valid;
            s_scan_byte <= next_byte;
        end
    end

    // Receiver, with one long hold-off that backs the block up into its input.
    always @(negedge aclk) begin
        if (aresetn) begin
            next_ready = 1'b1;
            if (stall_left != 0) begin
                next_ready = 1'b0;
                stall_left--;
            end else if (!long_done && out_count >= 400) begin
                long_done  = 1'b1;
                next_ready = 1'b0;
                stall_left = LONG_STALL - 1;
            end else if (pending.size() >= 100 && ((out_count / 70) % 3) != 1 &&
                         $urandom_range(0, 4) == 0) begin
                next_ready = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            m_ready <= next_ready;
        end
    end

    initial begin
        int          sel;
        logic [7:0]  mods[5];
        logic [7:0]  ext_follow;

        mods = '{{1'b0, K_LCTRL}, {1'b0, K_LSHIFT}, {1'b0, K_RSHIFT},
                 {1'b0, K_LALT}, {1'b0, K_CAPS}};

        // Directed: null make, shift and caps on letters and digits, ctrl folding,
        // double prefix, right ctrl and alt, other extended make, odd breaks, unknowns.
        queue_byte(SC_NULL);
        queue_byte(SC_Q);
        queue_byte({1'b0, K_LSHIFT});
        queue_byte(SC_1);
        queue_byte(SC_Q);
        queue_byte({1'b1, K_LSHIFT});
        queue_byte({1'b0, K_LCTRL});
        queue_byte(SC_L);
        queue_byte(SC_U);
        queue_byte({1'b1, K_LCTRL});
        queue_byte({1'b0, K_CAPS});
        queue_byte(SC_1);
        queue_byte(SC_Q);
        queue_byte(KEY_PREFIX);
        queue_byte(KEY_PREFIX);
        queue_byte({1'b0, K_LALT});
        queue_byte(KEY_PREFIX);
        queue_byte({1'b1, K_LALT});
        queue_byte(KEY_PREFIX);
        queue_byte({1'b0, K_LCTRL});
        queue_byte(KEY_PREFIX);
        queue_byte(SC_HOME);
        queue_byte({1'b0, K_RSHIFT});
        queue_byte({1'b1, K_RSHIFT});
        queue_byte(SC_BREAK);
        queue_byte(SC_ALL_ONES);
        queue_byte(KEY_LIMIT);

        // Random typing: mostly keys and modifier presses, some extended pairs and noise.
        while (pending.size() < 27 + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                queue_byte(8'($urandom_range(1, SC_LAST_MAKE)));
            end else if (sel < 65) begin
                if ($urandom_range(0, 3) == 0)
                    queue_byte(SC_BREAK | 8'($urandom_range(0, 127)));
                else
                    queue_byte(SC_BREAK | mods[$urandom_range(0, 4)]);
            end else if (sel < 77) begin
                queue_byte(mods[$urandom_range(0, 4)]);
            end else if (sel < 88) begin
                case ($urandom_range(0, 5))
                    0: ext_follow = {1'b0, K_LCTRL};
                    1: ext_follow = {1'b0, K_LALT};
                    2: ext_follow = {1'b1, K_LCTRL};
                    3: ext_follow = {1'b1, K_LALT};
                    4: ext_follow = 8'($urandom_range(0, 255));
                    default: ext_follow = KEY_PREFIX;
                endcase
                queue_byte(KEY_PREFIX);
                queue_byte(ext_follow);
            end else begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid)
            @(negedge aclk);
        while (exp_keys.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (errors == 0 && exp_keys.size() == 0)
            $display("[ps2_scancode_to_ascii] OK");
        else
            $display("[ps2_scancode_to_ascii] ERROR");
        $finish;
    end

endmodule
